// ===== rtl/core/mmh64b_pkg.sv =====
// ----------------------------------------------------------------------------
// mmh64b_pkg
// Shared constants, opcodes and controller/datapath interface types for the
// MurmurHash64B stream hasher.
// ----------------------------------------------------------------------------
package mmh64b_pkg;

  localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT  = 24;
  localparam logic [31:0] SEED_RESET = 32'h00114514;

  localparam int unsigned FIN_SHIFT_A = 18;
  localparam int unsigned FIN_SHIFT_B = 22;
  localparam int unsigned FIN_SHIFT_C = 17;
  localparam int unsigned FIN_SHIFT_D = 19;

  localparam int unsigned CFG_AW = 3;
  localparam logic [0:0]  REG_SEED = 1'b0;

  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_K1   = 4'd1,
    OP_K2   = 4'd2,
    OP_ACC  = 4'd3,
    OP_TAIL = 4'd4,
    OP_F0   = 4'd5,
    OP_F1   = 4'd6,
    OP_F2   = 4'd7,
    OP_F3   = 4'd8
  } mix_op_t;

  typedef struct packed {
    logic    load;
    mix_op_t op;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_stat_t;

endpackage

// ===== rtl/core/mmh64b_dp.sv =====
// ----------------------------------------------------------------------------
// mmh64b_dp
// Hash datapath: accumulators, word register, finalization registers and the
// result register, all sharing one 32-bit multiply by the mixing constant.
// ----------------------------------------------------------------------------
module mmh64b_dp
  import mmh64b_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [31:0] seed,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_first,
  input  logic [30:0] in_msg_length,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [63:0] out_hash_value,
  output dp_stat_t    stat
);

  logic [31:0] acc_high_r, acc_high_nxt;
  logic [31:0] acc_low_r, acc_low_nxt;
  logic        parity_r, parity_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] fin1_r, fin1_nxt;
  logic [31:0] fin2_r, fin2_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] hash_r, hash_nxt;
  logic [31:0] mul_in;
  logic [31:0] prod;
  logic [31:0] tail_mask;

  always_comb begin
    case (in_byte_count)
      3'd1:    tail_mask = 32'h000000ff;
      3'd2:    tail_mask = 32'h0000ffff;
      3'd3:    tail_mask = 32'h00ffffff;
      default: tail_mask = 32'hffffffff;
    endcase
  end

  always_comb begin
    case (cmd.op)
      OP_K1:   mul_in = word_r;
      OP_K2:   mul_in = word_r ^ (word_r >> MIX_SHIFT);
      OP_ACC:  mul_in = parity_r ? acc_low_r : acc_high_r;
      OP_TAIL: mul_in = acc_low_r ^ word_r;
      OP_F0:   mul_in = acc_high_r ^ (acc_low_r >> FIN_SHIFT_A);
      OP_F1:   mul_in = fin2_r ^ (fin1_r >> FIN_SHIFT_B);
      OP_F2:   mul_in = fin1_r ^ (fin2_r >> FIN_SHIFT_C);
      OP_F3:   mul_in = fin2_r ^ (fin1_r >> FIN_SHIFT_D);
      default: mul_in = '0;
    endcase
  end

  assign prod = mul_in * MIX_MUL;

  always_comb begin
    acc_high_nxt  = acc_high_r;
    acc_low_nxt   = acc_low_r;
    parity_nxt    = parity_r;
    word_nxt      = word_r;
    fin1_nxt      = fin1_r;
    fin2_nxt      = fin2_r;
    hash_nxt      = hash_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.load) begin
      word_nxt = in_data_word & tail_mask;
      if (in_first) begin
        acc_high_nxt = seed ^ {1'b0, in_msg_length};
        acc_low_nxt  = '0;
        parity_nxt   = 1'b0;
      end
    end
    case (cmd.op)
      OP_K1, OP_K2: begin
        word_nxt = prod;
      end
      OP_ACC: begin
        if (parity_r) begin
          acc_low_nxt = prod ^ word_r;
        end else begin
          acc_high_nxt = prod ^ word_r;
        end
        parity_nxt = ~parity_r;
      end
      OP_TAIL: begin
        acc_low_nxt = prod;
      end
      OP_F0: begin
        fin1_nxt = prod;
        fin2_nxt = acc_low_r;
      end
      OP_F1: begin
        fin2_nxt = prod;
      end
      OP_F2: begin
        fin1_nxt = prod;
      end
      default: begin
      end
    endcase
    if (cmd.out_load) begin
      hash_nxt      = {fin1_r, prod};
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_high_r  <= '0;
      acc_low_r   <= '0;
      parity_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_high_r  <= acc_high_nxt;
      acc_low_r   <= acc_low_nxt;
      parity_r    <= parity_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    fin1_r <= fin1_nxt;
    fin2_r <= fin2_nxt;
    hash_r <= hash_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = hash_r;
  assign stat.out_full  = out_valid_r && out_stall;

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("Result load did not raise the output valid.");

  a_acc_flips_parity: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_ACC) && !cmd.load |=> parity_r != $past(parity_r))
    else $error("Accumulator fold did not alternate the word parity.");

  a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(hash_r))
    else $error("Stalled result changed before it was taken.");

endmodule

// ===== rtl/core/mmh64b_ctrl.sv =====
// ----------------------------------------------------------------------------
// mmh64b_ctrl
// Sequencer for the hash datapath: accepts a word, steps the shared multiply
// through word mixing, tail absorption and the four finalization rounds.
// ----------------------------------------------------------------------------
module mmh64b_ctrl
  import mmh64b_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_byte_count,
  input  logic       in_last,
  output logic       in_stall,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_K1   = 9'b000000010,
    ST_K2   = 9'b000000100,
    ST_ACC  = 9'b000001000,
    ST_TAIL = 9'b000010000,
    ST_F0   = 9'b000100000,
    ST_F1   = 9'b001000000,
    ST_F2   = 9'b010000000,
    ST_F3   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt    = state_r;
    last_nxt     = last_r;
    cmd.load     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          last_nxt = in_last;
          if (in_byte_count[2]) begin
            state_nxt = ST_K1;
          end else if (in_byte_count != 3'd0) begin
            state_nxt = ST_TAIL;
          end else if (in_last) begin
            state_nxt = ST_F0;
          end
        end
      end
      ST_K1: begin
        cmd.op    = OP_K1;
        state_nxt = ST_K2;
      end
      ST_K2: begin
        cmd.op    = OP_K2;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = last_r ? ST_F0 : ST_IDLE;
      end
      ST_TAIL: begin
        cmd.op    = OP_TAIL;
        state_nxt = last_r ? ST_F0 : ST_IDLE;
      end
      ST_F0: begin
        cmd.op    = OP_F0;
        state_nxt = ST_F1;
      end
      ST_F1: begin
        cmd.op    = OP_F1;
        state_nxt = ST_F2;
      end
      ST_F2: begin
        cmd.op    = OP_F2;
        state_nxt = ST_F3;
      end
      ST_F3: begin
        cmd.op = OP_F3;
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  a_full_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_byte_count[2] |=> state_r == ST_K1 ##1 state_r == ST_K2
    ##1 state_r == ST_ACC)
    else $error("Full word did not run the three multiply steps in order.");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last && (in_byte_count == 3'd0) |=> state_r == ST_F0)
    else $error("Empty last word did not start finalization.");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (state_r == ST_F3) && !stat.out_full)
    else $error("Result loaded while the output register was held.");

endmodule

// ===== rtl/core/murmur64b_stream_hash.sv =====
// ----------------------------------------------------------------------------
// murmur64b_stream_hash
// MurmurHash64B over a stream of little-endian 32-bit words.
//
// The input channel carries one word per transfer with its byte count and
// first/last flags; the first word also carries the message length, which is
// XORed with the seed register to start the first accumulator. After the
// accept, a full word makes three passes through the single 32-bit
// multiplier (two to mix the word, one to fold it into an accumulator); a
// tail word of one to three bytes is XORed into the low accumulator, which
// is then multiplied. The last word adds four finalization rounds on the
// same multiplier, after which the hash is loaded into the output register.
// The output register holds one hash; the next message's words are accepted
// while it waits. If the receiver stalls and a second hash is ready, the
// block holds in its final round until the register is free.
// Reset clears both accumulators, the word parity and the output valid, and
// sets the seed to 0x114514. The seed is written over the APB port at byte
// address 0 and should only change while the block is idle.
// ----------------------------------------------------------------------------
module murmur64b_stream_hash
  import mmh64b_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       in_data_word,
  input  logic [2:0]        in_byte_count,
  input  logic              in_first,
  input  logic              in_last,
  input  logic [30:0]       in_msg_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [63:0]       out_hash_value,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0] seed_r, seed_nxt;
  logic        seed_sel;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign pready   = 1'b1;
  assign seed_sel = (paddr[2:2] == REG_SEED);
  assign prdata   = seed_sel ? seed_r : 32'h0;

  always_comb begin
    seed_nxt = seed_r;
    if (psel && penable && pwrite && seed_sel) begin
      seed_nxt = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  mmh64b_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_byte_count (in_byte_count),
    .in_last       (in_last),
    .in_stall      (in_stall),
    .stat          (stat),
    .cmd           (cmd)
  );

  mmh64b_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .seed           (seed_r),
    .in_data_word   (in_data_word),
    .in_byte_count  (in_byte_count),
    .in_first       (in_first),
    .in_msg_length  (in_msg_length),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_hash_value (out_hash_value),
    .stat           (stat)
  );

endmodule
